FILE: src/bfa_pkg.sv
// Package for the bitmap frame allocator: sizes, operation and status codes,
// FSM state type and the lowest-free-bit search. No dependencies.
package bfa_pkg;

    // Bitmap geometry
    localparam int MAX_FRAMES  = 4096;
    localparam int WORD_BITS   = 32;
    localparam int NWORDS      = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int WIDX_W      = $clog2(NWORDS);
    localparam int FIDX_W      = $clog2(MAX_FRAMES);

    // Port field widths
    localparam int MODE_W      = 3;
    localparam int ADDR_W      = 32;
    localparam int COUNT_W     = 13;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 13;
    localparam int FRAME_SHIFT = 12;
    localparam int FRAME_W     = ADDR_W - FRAME_SHIFT;
    localparam int HI_W        = FRAME_W + 1;
    localparam int LIM_W       = $clog2(MAX_FRAMES + 1);

    localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(4096);
    localparam logic [ADDR_W-1:0] NONE_ADDR = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC      = 3'd0,
        MODE_FREE_ONE   = 3'd1,
        MODE_FREE_RANGE = 3'd2,
        MODE_RSV_RANGE  = 3'd3,
        MODE_MARK_ALL   = 3'd4
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_NO_FREE      = 2'd1,
        ST_OUT_OF_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_RUN
    } t_state;

    // Index of the lowest set bit of a word (0 when none is set)
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) pos = BIT_W'(i);
        end
        return pos;
    endfunction

endpackage

FILE: src/bitmap_frame_allocator.sv
// Top level of the bitmap frame allocator: FSM, bitmap word memory and
// per-word valid bits. Depends on bfa_pkg.
//
// Usage:
//   Command channel: an item (i_mode, i_address, i_frame_count) is taken at a
//   rising edge with start high and busy low. busy stays high until the result
//   strobe o_result_valid rises; a new item can be taken in the strobe cycle.
//   Result channel: o_status and o_frame_address are valid for exactly one
//   cycle with o_result_valid. The receiver cannot stall; it must take them.
//   Config channel: i_cfg_data (managed frame count) is written at an edge with
//   i_cfg_valid and o_cfg_ready high; o_cfg_ready is high while idle.
// Completion (accept edge to strobe):
//   mark-all-used, unknown modes, alloc with no managed frames, empty or fully
//   out-of-range ops: strobe straight from S_SETUP.
//   free one, ranges: S_SETUP, then S_RUN over the bitmap words the clipped run touches.
//   alloc: S_SETUP, then S_RUN over the words up to and including the first one
//   with a free frame (at most 128). One 32-frame word is read per cycle and, when
//   modified, written back through the single-read, single-write bitmap memory.
// Reset: all frames used (per-word valid bits cleared, invalid words read as
//   all ones), managed count 4096. Mark-all-used clears the valid bits at once.
module bitmap_frame_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bfa_pkg::MODE_W-1:0]    i_mode,
    input  logic [bfa_pkg::ADDR_W-1:0]    i_address,
    input  logic [bfa_pkg::COUNT_W-1:0]   i_frame_count,
    output logic                          o_result_valid,
    output logic [bfa_pkg::STATUS_W-1:0]  o_status,
    output logic [bfa_pkg::ADDR_W-1:0]    o_frame_address,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bfa_pkg::CFG_W-1:0]     i_cfg_data
);
    import bfa_pkg::*;

    // Control registers
    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_managed;
    logic                r_find, n_find;
    logic                r_set, n_set;
    logic                r_range_err, n_range_err;
    logic [FIDX_W-1:0]   r_lo, n_lo;
    logic [FIDX_W-1:0]   r_last, n_last;
    logic [WIDX_W-1:0]   r_rd_w, n_rd_w;
    logic [WIDX_W-1:0]   r_rd_last, n_rd_last;
    logic                r_issue, n_issue;
    logic                r_pend, n_pend;
    logic [WIDX_W-1:0]   r_pend_w, n_pend_w;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [ADDR_W-1:0]   r_out_addr, n_out_addr;
    logic [NWORDS-1:0]   r_vld;
    logic                r_vld_q;

    // Captured item
    logic [MODE_W-1:0]   r_mode;
    logic [FRAME_W-1:0]  r_frame;
    logic [COUNT_W-1:0]  r_count;

    // Memory
    logic [WORD_BITS-1:0] mem_bitmap [NWORDS];
    logic [WORD_BITS-1:0] r_mem_q;
    logic                 mem_re, mem_we, vld_clear;
    logic [WIDX_W-1:0]    rd_addr, wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // Datapath helpers
    logic                 accept;
    logic [LIM_W-1:0]     limit;
    logic [COUNT_W-1:0]   eff_count;
    logic [HI_W-1:0]      hi;
    logic                 range_out;
    logic [LIM_W-1:0]     eff_hi;
    logic                 range_empty;
    logic [LIM_W-1:0]     eff_hi_m1;
    logic [LIM_W-1:0]     limit_m1;
    logic [WORD_BITS-1:0] word_q;
    logic [WORD_BITS-1:0] first_mask, last_mask, word_mask, free_bits;
    logic [BIT_W-1:0]     free_pos;

    assign accept      = start && (r_state == S_IDLE);
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    // Frames in force
    assign limit    = (LIM_W'(r_managed) > LIM_W'(MAX_FRAMES)) ? LIM_W'(MAX_FRAMES)
                                                               : LIM_W'(r_managed);
    assign limit_m1 = limit - LIM_W'(1);

    // Clip a run against the managed count
    assign eff_count   = (t_mode'(r_mode) == MODE_FREE_ONE) ? COUNT_W'(1) : r_count;
    assign hi          = {1'b0, r_frame} + HI_W'(eff_count);
    assign range_out   = (eff_count != '0) && (hi > HI_W'(limit));
    assign eff_hi      = range_out ? limit : hi[LIM_W-1:0];
    assign range_empty = (eff_count == '0) || ({1'b0, r_frame} >= HI_W'(eff_hi));
    assign eff_hi_m1   = eff_hi - LIM_W'(1);

    // Word being processed, with edge masks of the run
    assign word_q     = r_vld_q ? r_mem_q : '1;
    assign first_mask = (r_pend_w == r_lo[FIDX_W-1:BIT_W])
                      ? ({WORD_BITS{1'b1}} << r_lo[BIT_W-1:0]) : '1;
    assign last_mask  = (r_pend_w == r_last[FIDX_W-1:BIT_W])
                      ? ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - r_last[BIT_W-1:0]))
                      : '1;
    assign word_mask  = first_mask & last_mask;
    assign free_bits  = ~word_q & word_mask;
    assign free_pos   = lowest_set(free_bits);

    assign rd_addr = r_rd_w;
    assign wr_addr = r_pend_w;

    // Next state, memory commands and results
    always_comb begin
        n_state      = r_state;
        n_find       = r_find;
        n_set        = r_set;
        n_range_err  = r_range_err;
        n_lo         = r_lo;
        n_last       = r_last;
        n_rd_w       = r_rd_w;
        n_rd_last    = r_rd_last;
        n_issue      = r_issue;
        n_pend       = r_pend;
        n_pend_w     = r_pend_w;
        n_out_valid  = 1'b0;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        wr_data      = word_q;
        vld_clear    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_SETUP;
            end

            S_SETUP: begin
                n_out_addr = NONE_ADDR;
                n_issue    = 1'b0;
                n_pend     = 1'b0;
                unique case (t_mode'(r_mode)) inside
                    MODE_ALLOC: begin
                        if (limit == '0) begin
                            n_out_valid  = 1'b1;
                            n_out_status = ST_NO_FREE;
                            n_state      = S_IDLE;
                        end else begin
                            n_find    = 1'b1;
                            n_lo      = '0;
                            n_last    = limit_m1[FIDX_W-1:0];
                            n_rd_w    = '0;
                            n_rd_last = limit_m1[FIDX_W-1:BIT_W];
                            n_issue   = 1'b1;
                            n_state   = S_RUN;
                        end
                    end
                    MODE_FREE_ONE, MODE_FREE_RANGE, MODE_RSV_RANGE: begin
                        if (range_empty) begin
                            n_out_valid  = 1'b1;
                            n_out_status = range_out ? ST_OUT_OF_RANGE : ST_OK;
                            n_state      = S_IDLE;
                        end else begin
                            n_find      = 1'b0;
                            n_set       = (t_mode'(r_mode) == MODE_RSV_RANGE);
                            n_range_err = range_out;
                            n_lo        = r_frame[FIDX_W-1:0];
                            n_last      = eff_hi_m1[FIDX_W-1:0];
                            n_rd_w      = r_frame[FIDX_W-1:BIT_W];
                            n_rd_last   = eff_hi_m1[FIDX_W-1:BIT_W];
                            n_issue     = 1'b1;
                            n_state     = S_RUN;
                        end
                    end
                    MODE_MARK_ALL: begin
                        vld_clear    = 1'b1;
                        n_out_valid  = 1'b1;
                        n_out_status = ST_OK;
                        n_state      = S_IDLE;
                    end
                    default: begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_OK;
                        n_state      = S_IDLE;
                    end
                endcase
            end

            S_RUN: begin
                // Issue the next word read
                n_pend = 1'b0;
                if (r_issue) begin
                    mem_re   = 1'b1;
                    n_pend   = 1'b1;
                    n_pend_w = r_rd_w;
                    if (r_rd_w == r_rd_last) n_issue = 1'b0;
                    else n_rd_w = r_rd_w + WIDX_W'(1);
                end
                // Modify and write back the word that arrived
                if (r_pend) begin
                    if (r_find) begin
                        if (free_bits != '0) begin
                            mem_we       = 1'b1;
                            wr_data      = word_q | (WORD_BITS'(1) << free_pos);
                            n_out_valid  = 1'b1;
                            n_out_status = ST_OK;
                            n_out_addr   = ADDR_W'({r_pend_w, free_pos}) << FRAME_SHIFT;
                            n_state      = S_IDLE;
                            n_issue      = 1'b0;
                            n_pend       = 1'b0;
                        end else if (r_pend_w == r_rd_last) begin
                            n_out_valid  = 1'b1;
                            n_out_status = ST_NO_FREE;
                            n_out_addr   = NONE_ADDR;
                            n_state      = S_IDLE;
                            n_issue      = 1'b0;
                            n_pend       = 1'b0;
                        end
                    end else begin
                        mem_we  = 1'b1;
                        wr_data = r_set ? (word_q | word_mask) : (word_q & ~word_mask);
                        if (r_pend_w == r_rd_last) begin
                            n_out_valid  = 1'b1;
                            n_out_status = r_range_err ? ST_OUT_OF_RANGE : ST_OK;
                            n_out_addr   = NONE_ADDR;
                            n_state      = S_IDLE;
                            n_issue      = 1'b0;
                            n_pend       = 1'b0;
                        end
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control registers, valid bits and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_managed    <= CFG_RESET;
            r_find       <= 1'b0;
            r_set        <= 1'b0;
            r_range_err  <= 1'b0;
            r_lo         <= '0;
            r_last       <= '0;
            r_rd_w       <= '0;
            r_rd_last    <= '0;
            r_issue      <= 1'b0;
            r_pend       <= 1'b0;
            r_pend_w     <= '0;
            r_out_valid  <= 1'b0;
            r_out_status <= ST_OK;
            r_out_addr   <= NONE_ADDR;
            r_vld        <= '0;
            r_vld_q      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_find       <= n_find;
            r_set        <= n_set;
            r_range_err  <= n_range_err;
            r_lo         <= n_lo;
            r_last       <= n_last;
            r_rd_w       <= n_rd_w;
            r_rd_last    <= n_rd_last;
            r_issue      <= n_issue;
            r_pend       <= n_pend;
            r_pend_w     <= n_pend_w;
            r_out_valid  <= n_out_valid;
            r_out_status <= n_out_status;
            r_out_addr   <= n_out_addr;
            if (i_cfg_valid && o_cfg_ready) r_managed <= i_cfg_data;
            if (mem_re) r_vld_q <= r_vld[rd_addr];
            if (vld_clear) r_vld <= '0;
            else if (mem_we) r_vld[wr_addr] <= 1'b1;
        end
    end

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_mode;
            r_frame <= i_address[ADDR_W-1:FRAME_SHIFT];
            r_count <= i_frame_count;
        end
    end

    // Bitmap memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) mem_bitmap[wr_addr] <= wr_data;
        if (mem_re) r_mem_q <= mem_bitmap[rd_addr];
    end

    assign o_result_valid  = r_out_valid;
    assign o_status        = r_out_status;
    assign o_frame_address = r_out_addr;

`ifndef SYNTH
    // A result only follows work in progress
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state) != S_IDLE)
        else $error("result strobe without an item in progress");

    // Any failure returns the no-address value
    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != ST_OK) |-> o_frame_address == NONE_ADDR)
        else $error("failed item returned a frame address");

    // An allocated frame is aligned and inside the managed count
    a_alloc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_frame_address != NONE_ADDR)
        |-> (o_frame_address[FRAME_SHIFT-1:0] == '0)
            && (HI_W'(o_frame_address[ADDR_W-1:FRAME_SHIFT]) < HI_W'(limit)))
        else $error("allocated frame outside managed range");

    // Read-ahead never targets the word being written back
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> wr_addr != rd_addr)
        else $error("read and write of the same bitmap word in one cycle");
`endif

endmodule

FILE: sim/tb_bitmap_frame_allocator.sv
// Self-checking testbench for bitmap_frame_allocator: a directed table, then random
// phases under several managed frame counts, checked against an in-bench bitmap model.
// Depends on bfa_pkg and the bitmap_frame_allocator RTL.
module tb_bitmap_frame_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import bfa_pkg::*;

    // Modes the block must treat as no-ops
    localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 45;

    typedef struct {
        t_status              status;
        logic [ADDR_W-1:0]    frame_address;
    } t_frame_result;

    typedef struct {
        logic                 is_cfg;
        logic [CFG_W-1:0]     cfg_value;
        logic [MODE_W-1:0]    mode;
        logic [ADDR_W-1:0]    addr;
        logic [COUNT_W-1:0]   count;
        logic                 typed;
        t_status              want_status;
        logic [ADDR_W-1:0]    want_addr;
    } t_frame_op;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [MODE_W-1:0]     i_mode;
    logic [ADDR_W-1:0]     i_address;
    logic [COUNT_W-1:0]    i_frame_count;
    logic                  o_result_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [ADDR_W-1:0]     o_frame_address;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_W-1:0]      i_cfg_data;

    // Shadow of the block state
    logic [MAX_FRAMES-1:0] used_frames;
    logic [CFG_W-1:0]      managed_count;

    t_frame_result         awaited_results[$];
    t_frame_op             directed_ops[$];
    int                    fail_count = 0;

    bitmap_frame_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_address       (i_address),
        .i_frame_count   (i_frame_count),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_frame_address (o_frame_address),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Run one operation on the shadow bitmap and return the result it gives
    function automatic t_frame_result apply_frame_op(logic [MODE_W-1:0] mode,
                                                     logic [ADDR_W-1:0] addr,
                                                     logic [COUNT_W-1:0] count);
        t_frame_result r;
        int            lim;
        int            frame;
        int            f;
        logic          found;
        lim   = (managed_count > CFG_W'(MAX_FRAMES)) ? MAX_FRAMES : int'(managed_count);
        frame = int'(addr >> FRAME_SHIFT);
        found = 1'b0;
        r.status        = ST_OK;
        r.frame_address = NONE_ADDR;
        case (mode) inside
            MODE_ALLOC: begin
                r.status = ST_NO_FREE;
                for (int i = 0; i < lim; i++) begin
                    if (!found && !used_frames[i]) begin
                        found           = 1'b1;
                        used_frames[i]  = 1'b1;
                        r.frame_address = ADDR_W'(i) << FRAME_SHIFT;
                        r.status        = ST_OK;
                    end
                end
            end
            MODE_FREE_ONE: begin
                if (frame < lim) used_frames[frame] = 1'b0;
                else r.status = ST_OUT_OF_RANGE;
            end
            MODE_FREE_RANGE, MODE_RSV_RANGE: begin
                for (int i = 0; i < int'(count); i++) begin
                    f = frame + i;
                    if (f < lim) used_frames[f] = (mode == MODE_RSV_RANGE);
                    else r.status = ST_OUT_OF_RANGE;
                end
            end
            MODE_MARK_ALL: begin
                used_frames = '1;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_frame_op op_row(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr,
                                         logic [COUNT_W-1:0] count, logic typed,
                                         t_status st, logic [ADDR_W-1:0] fa);
        t_frame_op op;
        op.is_cfg      = 1'b0;
        op.cfg_value   = '0;
        op.mode        = mode;
        op.addr        = addr;
        op.count       = count;
        op.typed       = typed;
        op.want_status = st;
        op.want_addr   = fa;
        return op;
    endfunction

    function automatic t_frame_op cfg_row(logic [CFG_W-1:0] value);
        t_frame_op op;
        op           = op_row(MODE_ALLOC, '0, '0, 1'b0, ST_OK, NONE_ADDR);
        op.is_cfg    = 1'b1;
        op.cfg_value = value;
        return op;
    endfunction

    // Mostly frames near the managed range with random offsets, some raw noise
    function automatic t_frame_op rand_frame_op();
        t_frame_op op;
        int        lim;
        int        pick;
        lim  = (managed_count > CFG_W'(MAX_FRAMES)) ? MAX_FRAMES : int'(managed_count);
        op   = op_row(MODE_ALLOC, '0, '0, 1'b0, ST_OK, NONE_ADDR);
        pick = $urandom_range(0, 99);
        if (pick < 38)      op.mode = MODE_ALLOC;
        else if (pick < 60) op.mode = MODE_FREE_ONE;
        else if (pick < 74) op.mode = MODE_FREE_RANGE;
        else if (pick < 86) op.mode = MODE_RSV_RANGE;
        else if (pick < 90) op.mode = MODE_MARK_ALL;
        else                op.mode = MODE_W'($urandom_range(5, 7));
        if ($urandom_range(0, 4) != 0)
            op.addr = {FRAME_W'($urandom_range(0, lim + 8)), FRAME_SHIFT'($urandom)};
        else
            op.addr = $urandom;
        pick = $urandom_range(0, 9);
        if (pick < 7)       op.count = COUNT_W'($urandom_range(0, 40));
        else if (pick < 9)  op.count = COUNT_W'($urandom_range(0, 300));
        else                op.count = COUNT_W'($urandom_range(0, 8191));
        return op;
    endfunction

    // Drop start and hold the command side for the requested gap
    task automatic hold_off(int n);
        if (start) start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic maybe_gap(logic enable);
        if (enable && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 15));
    endtask

    // Hold the command side until every outstanding result is back
    task automatic wait_idle();
        if (start) start <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_managed_count(logic [CFG_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        managed_count = value;
        i_cfg_valid  <= 1'b0;
    endtask

    // Present one item, wait for the accept edge, record what it should return
    task automatic issue_item(t_frame_op op);
        t_frame_result r;
        start         <= 1'b1;
        i_mode        <= op.mode;
        i_address     <= op.addr;
        i_frame_count <= op.count;
        do @(posedge i_clk); while (busy !== 1'b0);
        r = apply_frame_op(op.mode, op.addr, op.count);
        if (op.typed) begin
            r.status        = op.want_status;
            r.frame_address = op.want_addr;
        end
        awaited_results.push_back(r);
    endtask

    // Compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_frame_result want;
        if (o_result_valid === 1'b1) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: status %0d frame_address %h",
                       o_status, o_frame_address);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_frame_address !== want.frame_address) begin
                    $error("frame_address: expected %h, got %h",
                           want.frame_address, o_frame_address);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #1_000_000;
        $display("bitmap_frame_allocator verification failed");
        $finish;
    end

    initial begin
        t_frame_op op;
        logic      gaps_on;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_mode        <= '0;
        i_address     <= '0;
        i_frame_count <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        used_frames    = '1;
        managed_count  = CFG_RESET;

        // After reset every frame is used; then extremes, no-op modes, edge frames
        directed_ops.push_back(op_row(MODE_ALLOC, '0, '0, 1'b1, ST_NO_FREE, NONE_ADDR));
        directed_ops.push_back(op_row(MODE_FREE_ONE, 32'h0000_0FFF, '0, 1'b1, ST_OK,
                                      NONE_ADDR));
        directed_ops.push_back(op_row(MODE_ALLOC, '0, '0, 1'b1, ST_OK, 32'h0));
        directed_ops.push_back(op_row(MODE_FREE_RANGE, '0, 13'd4096, 1'b1, ST_OK, NONE_ADDR));
        directed_ops.push_back(op_row(MODE_ALLOC, '0, '0, 1'b1, ST_OK, 32'h0));
        directed_ops.push_back(op_row(MODE_ALLOC, '0, '0, 1'b1, ST_OK, 32'h1000));
        directed_ops.push_back(op_row(MODE_RSV_RANGE, 32'h3000, '0, 1'b1, ST_OK, NONE_ADDR));
        directed_ops.push_back(op_row(MODE_FREE_ONE, '1, '0, 1'b1, ST_OUT_OF_RANGE,
                                      NONE_ADDR));
        directed_ops.push_back(op_row(MODE_FREE_RANGE, 32'h00FF_F000, '1, 1'b1,
                                      ST_OUT_OF_RANGE, NONE_ADDR));
        directed_ops.push_back(op_row(MODE_RSV_RANGE, 32'hFFFF_F000, 13'd1, 1'b1,
                                      ST_OUT_OF_RANGE, NONE_ADDR));
        directed_ops.push_back(op_row(MODE_RSVD5, '1, '1, 1'b1, ST_OK, NONE_ADDR));
        directed_ops.push_back(op_row(MODE_RSVD6, '0, '0, 1'b1, ST_OK, NONE_ADDR));
        directed_ops.push_back(op_row(MODE_RSVD7, 32'h5555_5555, 13'h0AAA, 1'b1,
                                      ST_OK, NONE_ADDR));
        directed_ops.push_back(op_row(MODE_RSV_RANGE, '0, 13'd4096, 1'b1, ST_OK, NONE_ADDR));
        directed_ops.push_back(op_row(MODE_ALLOC, '0, '0, 1'b1, ST_NO_FREE, NONE_ADDR));
        directed_ops.push_back(op_row(MODE_FREE_ONE, 32'h00FF_FFFF, '0, 1'b1, ST_OK,
                                      NONE_ADDR));
        directed_ops.push_back(op_row(MODE_ALLOC, '0, '0, 1'b1, ST_OK, 32'h00FF_F000));
        directed_ops.push_back(op_row(MODE_FREE_RANGE, 32'h5000, 13'd40, 1'b0, ST_OK,
                                      NONE_ADDR));
        directed_ops.push_back(op_row(MODE_ALLOC, '0, '0, 1'b0, ST_OK, NONE_ADDR));
        directed_ops.push_back(op_row(MODE_MARK_ALL, '0, '0, 1'b1, ST_OK, NONE_ADDR));
        directed_ops.push_back(op_row(MODE_ALLOC, '0, '0, 1'b1, ST_NO_FREE, NONE_ADDR));
        // No managed frames at all
        directed_ops.push_back(cfg_row(13'd0));
        directed_ops.push_back(op_row(MODE_ALLOC, '0, '0, 1'b1, ST_NO_FREE, NONE_ADDR));
        directed_ops.push_back(op_row(MODE_FREE_ONE, '0, '0, 1'b1, ST_OUT_OF_RANGE,
                                      NONE_ADDR));
        directed_ops.push_back(op_row(MODE_FREE_RANGE, '0, '0, 1'b1, ST_OK, NONE_ADDR));
        directed_ops.push_back(op_row(MODE_RSV_RANGE, '0, 13'd1, 1'b1,
                                      ST_OUT_OF_RANGE, NONE_ADDR));
        // Single managed frame, then a count above the bitmap size
        directed_ops.push_back(cfg_row(13'd1));
        directed_ops.push_back(op_row(MODE_FREE_ONE, '0, '0, 1'b1, ST_OK, NONE_ADDR));
        directed_ops.push_back(op_row(MODE_ALLOC, '0, '0, 1'b1, ST_OK, 32'h0));
        directed_ops.push_back(cfg_row(13'h1FFF));
        directed_ops.push_back(op_row(MODE_FREE_RANGE, 32'h1000, 13'd2, 1'b0, ST_OK,
                                      NONE_ADDR));
        directed_ops.push_back(op_row(MODE_ALLOC, '0, '0, 1'b0, ST_OK, NONE_ADDR));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (directed_ops[k]) begin
            if (directed_ops[k].is_cfg) begin
                write_managed_count(directed_ops[k].cfg_value);
            end else begin
                maybe_gap(1'b1);
                issue_item(directed_ops[k]);
            end
        end

        // Random phases, each under its own managed count; phase 3 and the last two run gap-free
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       write_managed_count(CFG_RESET);
                1:       write_managed_count(CFG_W'($urandom_range(1, 64)));
                2:       write_managed_count(13'd0);
                3:       write_managed_count(13'h1FFF);
                4:       write_managed_count(13'd1);
                5:       write_managed_count(CFG_W'($urandom_range(4097, 8190)));
                6:       write_managed_count(CFG_W'($urandom_range(1, 200)));
                default: write_managed_count(CFG_W'($urandom_range(1, 4096)));
            endcase
            gaps_on = (p != 3) && (p < RANDOM_PHASES - 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                maybe_gap(gaps_on);
                if (p == 1 && n == 20) wait_idle();
                op = rand_frame_op();
                issue_item(op);
            end
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("bitmap_frame_allocator verification clean");
        end else begin
            $display("bitmap_frame_allocator verification failed");
        end
        $finish;
    end

endmodule

FILE: bitmap_frame_allocator.f
src/bfa_pkg.sv
src/bitmap_frame_allocator.sv
sim/tb_bitmap_frame_allocator.sv
